>>> hdl/dmaft_pkg.sv
// Shared types and codes for the dual address filter table.
// No dependencies; every other file of the block but dmaft_chan_if imports this package.
package dmaft_pkg;

   localparam int ADDR_W  = 48;
   localparam int KIND_W  = 2;
   localparam int ENTRY_W = 5;
   localparam int COUNT_W = 6;
   localparam logic [COUNT_W-1:0] USED_MAX = 6'd63;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_CLEAR    = 3'd2,
      OP_CONTAINS = 3'd3,
      OP_GET      = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic               list_select;
      logic [ADDR_W-1:0]  address_in;
      logic [KIND_W-1:0]  kind_in;
      logic [ENTRY_W-1:0] entry_index;
   } req_payload_type;

   typedef struct packed {
      status_type         status;
      logic               hit;
      logic [ADDR_W-1:0]  address_out;
      logic [KIND_W-1:0]  kind_tag;
      logic [COUNT_W-1:0] used_count;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       add_en;
      logic       remove_en;
      logic       clear_en;
      logic       scan_clear;
      logic       scan_step;
      logic       rsp_load;
      logic       rsp_entry;
      status_type rsp_status;
      logic       rsp_hit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] operation;
      logic       match_any;
      logic       full;
      logic       slot_used;
      logic       slot_last;
      logic       seen_hit;
      logic       rsp_busy;
   } dp_status_type;

endpackage

>>> hdl/dmaft_chan_if.sv
// Valid/ready channel carrying one payload struct per request.
// Payload type is set per instance; used with dmaft_pkg structs.
interface dmaft_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/dmaft_ctrl.sv
// Sequencing state machine for the filter table: accept, decide, slot scan.
// Depends on dmaft_pkg; drives the datapath through cmd_type only.
module dmaft_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dmaft_pkg::dp_status_type sts,
   output dmaft_pkg::cmd_type     cmd
);
   import dmaft_pkg::*;

   state_type state_ff, state_in;
   logic      found;

   assign found = sts.slot_used && sts.seen_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!sts.rsp_busy) begin
               state_in = (sts.operation == OP_GET) ? S_SCAN : S_IDLE;
            end
         end
         S_SCAN: begin
            if ((found || sts.slot_last) && !sts.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_status = ST_OK;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
         end
         S_DECIDE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               unique case (sts.operation)
                  OP_ADD: begin
                     priority if (sts.match_any) begin
                        cmd.rsp_status = ST_PRESENT;
                     end else if (sts.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.add_en = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (sts.match_any) begin
                        cmd.remove_en = 1'b1;
                     end else begin
                        cmd.rsp_status = ST_NOT_FOUND;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear_en = 1'b1;
                  end
                  OP_CONTAINS: begin
                     cmd.rsp_hit = sts.match_any;
                  end
                  OP_GET: begin
                     // no result yet: walk the slots first
                     cmd.rsp_load   = 1'b0;
                     cmd.scan_clear = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            priority if (found) begin
               cmd.rsp_load  = !sts.rsp_busy;
               cmd.rsp_entry = 1'b1;
            end else if (sts.slot_last) begin
               cmd.rsp_load   = !sts.rsp_busy;
               cmd.rsp_status = ST_NOT_FOUND;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTH
   a_accept_to_decide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECIDE))
      else $error("accepted request did not move to decide");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !sts.rsp_busy)
      else $error("response loaded while previous one is still held");
`endif

endmodule

>>> hdl/dmaft_datapath.sv
// Table storage, parallel address compare, slot scan and response register.
// Depends on dmaft_pkg; commanded by dmaft_ctrl.
module dmaft_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dmaft_pkg::req_payload_type req_data,
   output dmaft_pkg::rsp_payload_type rsp_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  dmaft_pkg::cmd_type        cmd,
   output dmaft_pkg::dp_status_type  sts
);
   import dmaft_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SEEN_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
   localparam int SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // table payload, no reset: unused slots are never read out
   logic [ADDR_W-1:0] addr_mem_ff [2][TABLE_DEPTH];
   logic [KIND_W-1:0] kind_mem_ff [2][TABLE_DEPTH];

   logic [1:0][TABLE_DEPTH-1:0] used_ff, used_in;
   logic [1:0][CNT_W-1:0]       count_ff, count_in;
   logic [TABLE_DEPTH-1:0]      match_ff, match_in;
   req_payload_type             req_ff;
   logic [IDX_W-1:0]            scan_ff, scan_in;
   logic [SEEN_W-1:0]           seen_ff, seen_in;
   rsp_payload_type             rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        sel;
   logic [TABLE_DEPTH-1:0]      used_sel;
   logic [IDX_W-1:0]            free_idx;
   logic [IDX_W-1:0]            match_idx;
   logic [SAT_W-1:0]            count_ext;

   function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_DEPTH-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   assign sel       = req_ff.list_select;
   assign used_sel  = used_ff[sel];
   assign free_idx  = first_set(~used_sel);
   assign match_idx = first_set(match_ff);

   // compare every used slot of the requested list against the new address
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_in[i] = used_ff[req_data.list_select][i] &&
                       (addr_mem_ff[req_data.list_select][i] == req_data.address_in);
      end
   end

   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      if (cmd.add_en) begin
         used_in[sel][free_idx] = 1'b1;
         count_in[sel]          = count_ff[sel] + CNT_W'(1);
      end
      if (cmd.remove_en) begin
         used_in[sel][match_idx] = 1'b0;
         count_in[sel]           = count_ff[sel] - CNT_W'(1);
      end
      if (cmd.clear_en) begin
         used_in[sel]  = '0;
         count_in[sel] = '0;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      seen_in = seen_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
         seen_in = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + IDX_W'(1);
         seen_in = seen_ff + SEEN_W'(used_sel[scan_ff]);
      end
   end

   assign count_ext = SAT_W'(count_in[sel]);

   always_comb begin
      rsp_in.status      = cmd.rsp_status;
      rsp_in.hit         = cmd.rsp_hit;
      rsp_in.address_out = cmd.rsp_entry ? addr_mem_ff[sel][scan_ff] : '0;
      rsp_in.kind_tag    = cmd.rsp_entry ? kind_mem_ff[sel][scan_ff] : '0;
      rsp_in.used_count  = (count_ext > SAT_W'(USED_MAX)) ? USED_MAX
                                                          : count_ext[COUNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         match_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      seen_ff <= seen_in;
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (cmd.add_en) begin
         addr_mem_ff[sel][free_idx] <= req_ff.address_in;
         kind_mem_ff[sel][free_idx] <= req_ff.kind_in;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign sts.operation = req_ff.operation;
   assign sts.match_any = |match_ff;
   assign sts.full      = &used_sel;
   assign sts.slot_used = used_sel[scan_ff];
   assign sts.slot_last = (scan_ff == IDX_W'(TABLE_DEPTH - 1));
   assign sts.seen_hit  = (seen_ff == SEEN_W'(req_ff.entry_index));
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

`ifndef SYNTH
   a_count_tracks_used: assert property (@(posedge clock) disable iff (reset)
      ($countones(used_ff[0]) == int'(count_ff[0])) &&
      ($countones(used_ff[1]) == int'(count_ff[1])))
      else $error("used count out of step with used flags");
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("address found in more than one slot");
   a_add_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.add_en |-> (!(&used_sel) && !(|match_ff)))
      else $error("add written into a full list or over a duplicate");
`endif

endmodule

>>> hdl/dual_mac_address_filter_table_unit.sv
// Two 48-bit address lists (allow, deny), TABLE_DEPTH slots each, with add, remove,
// clear, contains and get-n-th-used operations; every request gives one response
// carrying the selected list's used count. A taken request is registered, and its
// response is registered in the decide state once no older response is held; get
// sets up the scan there instead, walks the slots one per cycle, stops at the wanted
// used slot or the last slot (TABLE_DEPTH-1) and registers its response once no older
// response is held. A new request is taken only once the previous one is finished; a
// held response does not block taking it, but the request then waits until the held
// response is taken. Reset clears both lists.
module dual_mac_address_filter_table_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   dmaft_chan_if.sink   req_chan,
   dmaft_chan_if.source rsp_chan
);
   import dmaft_pkg::*;

   cmd_type       cmd;
   dp_status_type sts;

   dmaft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dmaft_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_chan.data),
      .rsp_data  (rsp_chan.data),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

>>> test/dmaft_filter_checker.sv
`timescale 1ns / 100ps
// Checker for the dual address filter table: watches both channels, keeps its own copy
// of the allow and deny lists, predicts each response and compares it field by field.
// Depends on dmaft_pkg for the payload structs and operation/status codes.
module dmaft_filter_checker #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  dmaft_pkg::req_payload_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  dmaft_pkg::rsp_payload_type rsp_data,
   output int                         fail_count,
   output int                         pending_count
);
   import dmaft_pkg::*;

   logic [ADDR_W-1:0] slot_addr [2][TABLE_DEPTH];
   logic [KIND_W-1:0] slot_kind [2][TABLE_DEPTH];
   logic              slot_used [2][TABLE_DEPTH];

   rsp_payload_type expected_rsp_q[$];
   rsp_payload_type oldest_rsp;

   function automatic void empty_list(input logic sel);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_addr[sel][i] = '0;
         slot_kind[sel][i] = '0;
         slot_used[sel][i] = 1'b0;
      end
   endfunction

   function automatic int find_slot(input logic sel, input logic [ADDR_W-1:0] addr);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slot_used[sel][i] && slot_addr[sel][i] == addr)
            return i;
      return -1;
   endfunction

   function automatic logic [COUNT_W-1:0] count_used(input logic sel);
      int n;
      n = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slot_used[sel][i])
            n++;
      return (n > USED_MAX) ? USED_MAX : COUNT_W'(n);
   endfunction

   // Apply one request to the shadow lists and return the response it should give.
   function automatic rsp_payload_type apply_filter_op(input req_payload_type r);
      rsp_payload_type rsp;
      logic            sel;
      int              slot;
      int              seen;
      rsp  = '0;
      sel  = r.list_select;
      slot = find_slot(sel, r.address_in);
      case (r.operation)
         OP_ADD: begin
            if (slot >= 0) begin
               rsp.status = ST_PRESENT;
            end else begin
               rsp.status = ST_FULL;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!slot_used[sel][i]) begin
                     slot_addr[sel][i] = r.address_in;
                     slot_kind[sel][i] = r.kind_in;
                     slot_used[sel][i] = 1'b1;
                     rsp.status = ST_OK;
                     break;
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (slot < 0) begin
               rsp.status = ST_NOT_FOUND;
            end else begin
               slot_addr[sel][slot] = '0;
               slot_kind[sel][slot] = '0;
               slot_used[sel][slot] = 1'b0;
            end
         end
         OP_CLEAR: empty_list(sel);
         OP_CONTAINS: rsp.hit = (slot >= 0);
         OP_GET: begin
            rsp.status = ST_NOT_FOUND;
            seen = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[sel][i]) begin
                  if (seen == r.entry_index) begin
                     rsp.address_out = slot_addr[sel][i];
                     rsp.kind_tag    = slot_kind[sel][i];
                     rsp.status      = ST_OK;
                     break;
                  end
                  seen++;
               end
            end
         end
         default: ;
      endcase
      rsp.used_count = count_used(sel);
      return rsp;
   endfunction

   task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         empty_list(1'b0);
         empty_list(1'b1);
         expected_rsp_q.delete();
      end else begin
         // A response taken on the same edge as a request belongs to an older request.
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            end else begin
               oldest_rsp = expected_rsp_q.pop_front();
               check_field("status", ADDR_W'(oldest_rsp.status), ADDR_W'(rsp_data.status));
               check_field("hit", ADDR_W'(oldest_rsp.hit), ADDR_W'(rsp_data.hit));
               check_field("address_out", oldest_rsp.address_out, rsp_data.address_out);
               check_field("kind_tag", ADDR_W'(oldest_rsp.kind_tag),
                           ADDR_W'(rsp_data.kind_tag));
               check_field("used_count", ADDR_W'(oldest_rsp.used_count),
                           ADDR_W'(rsp_data.used_count));
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_filter_op(req_data));
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

>>> test/dual_mac_address_filter_table_unit_tb.sv
`timescale 1ns / 100ps
// Top of the testbench for dual_mac_address_filter_table_unit: clock, reset, request
// stimulus and response back-pressure; dmaft_filter_checker does the predicting.
// Depends on dmaft_pkg, dmaft_chan_if, the block and the checker.
module dual_mac_address_filter_table_unit_tb;
   import dmaft_pkg::*;

   localparam int         DEPTH            = 32;
   localparam int         POOL_SIZE        = 40;
   localparam int         RANDOM_PER_PHASE = 340;
   localparam logic [2:0] OP_UNUSED_FIRST  = 3'd5;
   localparam logic [2:0] OP_UNUSED_MID    = 3'd6;
   localparam logic [2:0] OP_UNUSED_LAST   = 3'd7;
   localparam logic       LIST_ALLOW       = 1'b0;
   localparam logic       LIST_DENY        = 1'b1;
   localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
   localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
   localparam logic [ADDR_W-1:0] ADDR_ALT0 = 48'hAAAA_AAAA_AAAA;
   localparam logic [ADDR_W-1:0] ADDR_ALT1 = 48'h5555_5555_5555;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   fail_count;
   int   pending_count;
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

   dmaft_chan_if #(.payload_type(req_payload_type)) req_chan ();
   dmaft_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   dual_mac_address_filter_table_unit #(.TABLE_DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dmaft_filter_checker #(.TABLE_DEPTH(DEPTH)) filter_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [ADDR_W-1:0] random_address();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [KIND_W-1:0] random_kind();
      return KIND_W'($urandom_range(3));
   endfunction

   function automatic logic [ENTRY_W-1:0] random_index();
      return ENTRY_W'($urandom_range(31));
   endfunction

   task automatic send_request(input logic [2:0] op, input logic sel,
                               input logic [ADDR_W-1:0] addr, input logic [KIND_W-1:0] kind,
                               input logic [ENTRY_W-1:0] idx);
      req_payload_type item;
      item.operation   = op;
      item.list_select = sel;
      item.address_in  = addr;
      item.kind_in     = kind;
      item.entry_index = idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Fill one list past capacity, then read entries back.
   task automatic fill_and_sweep(input logic sel);
      send_request(OP_CLEAR, sel, random_address(), random_kind(), random_index());
      for (int i = 0; i <= DEPTH; i++)
         send_request(OP_ADD, sel, addr_pool[i], random_kind(), random_index());
      send_request(OP_ADD, sel, addr_pool[$urandom_range(DEPTH - 1)], random_kind(),
                   random_index());
      for (int i = 0; i < 8; i++)
         send_request(OP_GET, sel, random_address(), random_kind(), random_index());
   endtask

   task automatic random_request();
      int                 pick;
      logic [2:0]         op;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] idx;
      pick = $urandom_range(99);
      if (pick < 38)      op = OP_ADD;
      else if (pick < 55) op = OP_REMOVE;
      else if (pick < 75) op = OP_CONTAINS;
      else if (pick < 94) op = OP_GET;
      else if (pick < 97) op = OP_CLEAR;
      else                op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      // Mostly pool addresses so adds collide and removes find something.
      addr = ($urandom_range(9) == 0) ? random_address()
                                      : addr_pool[$urandom_range(POOL_SIZE - 1)];
      idx  = $urandom_range(1) ? random_index() : ENTRY_W'($urandom_range(7));
      send_request(op, 1'($urandom_range(1)), addr, random_kind(), idx);
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      send_idle_pct = 38;
      recv_idle_pct = 85;
      addr_pool[0] = ADDR_ZERO;
      addr_pool[1] = ADDR_ONES;
      addr_pool[2] = ADDR_ALT0;
      addr_pool[3] = ADDR_ALT1;
      for (int i = 4; i < POOL_SIZE; i++)
         addr_pool[i] = random_address();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, extremes, duplicates, misses, unused codes, clears
      send_request(OP_CONTAINS, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_GET, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_ADD, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_ADD, LIST_ALLOW, ADDR_ONES, 2'd3, 5'd31);
      send_request(OP_ADD, LIST_ALLOW, ADDR_ONES, 2'd1, 5'd0);
      send_request(OP_CONTAINS, LIST_ALLOW, ADDR_ONES, 2'd0, 5'd0);
      send_request(OP_CONTAINS, LIST_DENY, ADDR_ONES, 2'd0, 5'd0);
      send_request(OP_GET, LIST_ALLOW, ADDR_ONES, 2'd3, 5'd0);
      send_request(OP_GET, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd1);
      send_request(OP_GET, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd2);
      send_request(OP_GET, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd31);
      send_request(OP_REMOVE, LIST_ALLOW, 48'h0123_4567_89AB, 2'd0, 5'd0);
      send_request(OP_REMOVE, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_ADD, LIST_ALLOW, ADDR_ALT1, 2'd2, 5'd0);
      send_request(OP_GET, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_GET, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd1);
      send_request(OP_UNUSED_FIRST, LIST_ALLOW, ADDR_ONES, 2'd3, 5'd31);
      send_request(OP_UNUSED_MID, LIST_DENY, ADDR_ALT0, 2'd1, 5'd10);
      send_request(OP_UNUSED_LAST, LIST_ALLOW, ADDR_ALT1, 2'd2, 5'd21);
      send_request(OP_ADD, LIST_DENY, ADDR_ALT0, 2'd1, 5'd0);
      send_request(OP_CLEAR, LIST_ALLOW, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_CONTAINS, LIST_ALLOW, ADDR_ONES, 2'd0, 5'd0);
      send_request(OP_GET, LIST_DENY, ADDR_ZERO, 2'd0, 5'd0);
      send_request(OP_CLEAR, LIST_DENY, ADDR_ONES, 2'd3, 5'd31);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 38; recv_idle_pct = 85; end
            1: begin send_idle_pct = 85; recv_idle_pct = 38; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         fill_and_sweep(phase[0]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            random_request();
      end
      req_chan.valid <= 1'b0;

      // let the checker record the last request, then drain
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3 * DEPTH) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
